>>> rtl/udisk_pkg.sv
// udisk_pkg: shared types, widths and constants of the uniform disk sampler.
// Depends on nothing; every rtl module takes its names from here by scope.
package udisk_pkg;

   // Field widths
   localparam int IN_BITS    = 16;
   localparam int OUT_BITS   = 16;
   localparam int PHASE_BITS = IN_BITS - 2;

   // Internal fixed-point widths (Q30 throughout)
   localparam int Q_FRAC     = 30;
   localparam int R_BITS     = 30;
   localparam int X_BITS     = 31;
   localparam int X2_BITS    = 32;
   localparam int H_BITS     = 31;
   localparam int N_BITS     = 32;
   localparam int RECIP_BITS = 33;
   localparam int PROD_BITS  = R_BITS + X_BITS;
   localparam int OUT_SHIFT  = 61 - OUT_BITS;

   // Pipeline depths
   localparam int SIN_TERMS   = 7;
   localparam int SQRT_STAGES = 15;
   localparam int SINE_LAT    = 2 * SIN_TERMS + 3;
   localparam int SCALE_LAT   = 2;
   localparam int CORE_LAT    = SINE_LAT + SCALE_LAT;

   localparam logic [X_BITS-1:0] HALF_PI_Q30 = 31'h6487ED51;
   localparam logic [H_BITS-1:0] Q30_ONE     = 31'h4000_0000;

   // Series denominators 210,156,110,72,42,20,6 as exact reciprocals:
   // n / k == (n * ceil(2^s / k)) >> s for every 32-bit n
   localparam int SIN_SHIFT [SIN_TERMS] = '{40, 40, 39, 39, 38, 37, 35};
   localparam logic [RECIP_BITS-1:0] SIN_RECIP [SIN_TERMS] = '{
      33'(((64'd1 << 40) + 64'd209) / 64'd210),
      33'(((64'd1 << 40) + 64'd155) / 64'd156),
      33'(((64'd1 << 39) + 64'd109) / 64'd110),
      33'(((64'd1 << 39) + 64'd71) / 64'd72),
      33'(((64'd1 << 38) + 64'd41) / 64'd42),
      33'(((64'd1 << 37) + 64'd19) / 64'd20),
      33'(((64'd1 << 35) + 64'd5) / 64'd6)
   };

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } udisk_quad_type;

   typedef struct packed {
      logic [IN_BITS-1:0] angle_fraction;
      logic [IN_BITS-1:0] radius_uniform;
   } udisk_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] point_x;
      logic signed [OUT_BITS-1:0] point_y;
   } udisk_rsp_type;

endpackage

>>> rtl/udisk_sqrt.sv
// udisk_sqrt: pipelined digit-by-digit square root of radius_uniform * 2^44.
// Two result bits per stage, SQRT_STAGES stages; uses udisk_pkg.
module udisk_sqrt (
   input  logic                             clock,
   input  logic [udisk_pkg::IN_BITS-1:0]    radius_uniform,
   output logic [udisk_pkg::R_BITS-1:0]     root
);

   logic [udisk_pkg::R_BITS:0]    rem_ff [udisk_pkg::SQRT_STAGES];
   logic [udisk_pkg::R_BITS-1:0]  res_ff [udisk_pkg::SQRT_STAGES];
   logic [udisk_pkg::IN_BITS-1:0] rad_ff [udisk_pkg::SQRT_STAGES];

   for (genvar k = 0; k < udisk_pkg::SQRT_STAGES; k++) begin : g_stage
      logic [udisk_pkg::R_BITS:0]    rem_src;
      logic [udisk_pkg::R_BITS-1:0]  res_src;
      logic [udisk_pkg::IN_BITS-1:0] rad_src;
      logic [udisk_pkg::R_BITS:0]    rem_in;
      logic [udisk_pkg::R_BITS-1:0]  res_in;
      logic [udisk_pkg::IN_BITS-1:0] rad_in;

      // Take the fresh radicand in the first stage, the previous stage after
      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign res_src = '0;
         assign rad_src = radius_uniform;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign res_src = res_ff[k-1];
         assign rad_src = rad_ff[k-1];
      end

      // Resolve two root bits, feeding two radicand bits each
      always_comb begin
         logic [udisk_pkg::R_BITS+2:0] acc;
         logic [udisk_pkg::R_BITS+2:0] trial;
         rem_in = rem_src;
         res_in = res_src;
         rad_in = rad_src;
         for (int j = 0; j < 2; j++) begin
            acc   = {rem_in, rad_in[udisk_pkg::IN_BITS-1 -: 2]};
            trial = {1'b0, res_in, 2'b01};
            if (acc >= trial) begin
               acc    = acc - trial;
               res_in = {res_in[udisk_pkg::R_BITS-2:0], 1'b1};
            end else begin
               res_in = {res_in[udisk_pkg::R_BITS-2:0], 1'b0};
            end
            rem_in = acc[udisk_pkg::R_BITS:0];
            rad_in = {rad_in[udisk_pkg::IN_BITS-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
         rad_ff[k] <= rad_in;
      end
   end

   assign root = res_ff[udisk_pkg::SQRT_STAGES-1];

endmodule

>>> rtl/udisk_sine.sv
// udisk_sine: pipelined quarter-wave sine over a phase of 0..2^14 steps.
// Nested Taylor series, two stages per term; uses udisk_pkg.
module udisk_sine (
   input  logic                               clock,
   input  logic [udisk_pkg::PHASE_BITS:0]     phase,
   output logic [udisk_pkg::X_BITS-1:0]       sine
);

   localparam int XP_BITS = udisk_pkg::PHASE_BITS + 1 + udisk_pkg::X_BITS;

   // Clamp 1.0 - d at zero
   function automatic logic [udisk_pkg::H_BITS-1:0] one_minus(
      input logic [udisk_pkg::N_BITS-1:0] d);
      logic [udisk_pkg::N_BITS-1:0] one_w;
      one_w = udisk_pkg::N_BITS'(udisk_pkg::Q30_ONE);
      if (d > one_w) begin
         return '0;
      end
      return udisk_pkg::H_BITS'(one_w - d);
   endfunction

   logic [udisk_pkg::X_BITS-1:0]  x1_ff;
   logic [udisk_pkg::X_BITS-1:0]  x2x_ff;
   logic [udisk_pkg::X2_BITS-1:0] sq_ff;
   logic [udisk_pkg::N_BITS-1:0]  n_ff   [udisk_pkg::SIN_TERMS];
   logic [udisk_pkg::X_BITS-1:0]  xa_ff  [udisk_pkg::SIN_TERMS];
   logic [udisk_pkg::X2_BITS-1:0] sqa_ff [udisk_pkg::SIN_TERMS];
   logic [udisk_pkg::N_BITS-1:0]  d_ff   [udisk_pkg::SIN_TERMS];
   logic [udisk_pkg::X_BITS-1:0]  xb_ff  [udisk_pkg::SIN_TERMS];
   logic [udisk_pkg::X2_BITS-1:0] sqb_ff [udisk_pkg::SIN_TERMS];
   logic [udisk_pkg::X_BITS-1:0]  sine_ff;

   logic [XP_BITS-1:0] xp;
   logic [2*udisk_pkg::X_BITS-1:0] xx;

   // Phase to radians, then radians squared
   assign xp = XP_BITS'(phase) * XP_BITS'(udisk_pkg::HALF_PI_Q30);
   assign xx = (2*udisk_pkg::X_BITS)'(x1_ff) * (2*udisk_pkg::X_BITS)'(x1_ff);

   always_ff @(posedge clock) begin
      x1_ff  <= xp[udisk_pkg::PHASE_BITS +: udisk_pkg::X_BITS];
      x2x_ff <= x1_ff;
      sq_ff  <= xx[udisk_pkg::Q_FRAC +: udisk_pkg::X2_BITS];
   end

   for (genvar i = 0; i < udisk_pkg::SIN_TERMS; i++) begin : g_term
      logic [udisk_pkg::H_BITS-1:0]  h;
      logic [udisk_pkg::X2_BITS-1:0] sq_src;
      logic [udisk_pkg::X_BITS-1:0]  x_src;
      logic [udisk_pkg::X2_BITS+udisk_pkg::H_BITS-1:0] nh;
      logic [udisk_pkg::N_BITS+udisk_pkg::RECIP_BITS-1:0] nr;

      if (i == 0) begin : g_first
         assign h      = udisk_pkg::Q30_ONE;
         assign sq_src = sq_ff;
         assign x_src  = x2x_ff;
      end else begin : g_next
         assign h      = one_minus(d_ff[i-1]);
         assign sq_src = sqb_ff[i-1];
         assign x_src  = xb_ff[i-1];
      end

      // Scale the running term by x^2, then divide by the series constant
      assign nh = (udisk_pkg::X2_BITS+udisk_pkg::H_BITS)'(sq_src)
                * (udisk_pkg::X2_BITS+udisk_pkg::H_BITS)'(h);
      assign nr = (udisk_pkg::N_BITS+udisk_pkg::RECIP_BITS)'(n_ff[i])
                * (udisk_pkg::N_BITS+udisk_pkg::RECIP_BITS)'(udisk_pkg::SIN_RECIP[i]);

      always_ff @(posedge clock) begin
         n_ff[i]   <= nh[udisk_pkg::Q_FRAC +: udisk_pkg::N_BITS];
         xa_ff[i]  <= x_src;
         sqa_ff[i] <= sq_src;
         d_ff[i]   <= udisk_pkg::N_BITS'(nr >> udisk_pkg::SIN_SHIFT[i]);
         xb_ff[i]  <= xa_ff[i];
         sqb_ff[i] <= sqa_ff[i];
      end
   end

   logic [udisk_pkg::H_BITS-1:0] h_last;
   logic [udisk_pkg::X_BITS+udisk_pkg::H_BITS-1:0] xh;

   // Final product x * h
   assign h_last = one_minus(d_ff[udisk_pkg::SIN_TERMS-1]);
   assign xh = (udisk_pkg::X_BITS+udisk_pkg::H_BITS)'(xb_ff[udisk_pkg::SIN_TERMS-1])
             * (udisk_pkg::X_BITS+udisk_pkg::H_BITS)'(h_last);

   always_ff @(posedge clock) begin
      sine_ff <= xh[udisk_pkg::Q_FRAC +: udisk_pkg::X_BITS];
   end

   assign sine = sine_ff;

endmodule

>>> rtl/udisk_scale.sv
// udisk_scale: radius times trig magnitude, round to nearest, sign, saturate.
// Two register stages; uses udisk_pkg.
module udisk_scale (
   input  logic                                 clock,
   input  logic [udisk_pkg::R_BITS-1:0]         radius,
   input  logic [udisk_pkg::X_BITS-1:0]         magnitude,
   input  logic                                 negative,
   output logic signed [udisk_pkg::OUT_BITS-1:0] value
);

   localparam int M_BITS = udisk_pkg::PROD_BITS + 1 - udisk_pkg::OUT_SHIFT;

   logic [udisk_pkg::PROD_BITS-1:0]  prod_ff;
   logic                             neg_ff;
   logic [udisk_pkg::OUT_BITS-1:0]   value_ff;

   logic [udisk_pkg::PROD_BITS:0] sum;
   logic [M_BITS-1:0]             m;
   logic [M_BITS-1:0]             pos_max;
   logic [M_BITS-1:0]             clamped;
   logic [udisk_pkg::OUT_BITS-1:0] value_in;

   // Multiply
   always_ff @(posedge clock) begin
      prod_ff <= udisk_pkg::PROD_BITS'(radius) * udisk_pkg::PROD_BITS'(magnitude);
      neg_ff  <= negative;
   end

   // Round half away from zero, clamp, apply sign
   always_comb begin
      sum     = (udisk_pkg::PROD_BITS+1)'(prod_ff)
              + ((udisk_pkg::PROD_BITS+1)'(1) << (udisk_pkg::OUT_SHIFT - 1));
      m       = sum[udisk_pkg::OUT_SHIFT +: M_BITS];
      pos_max = (M_BITS'(1) << (udisk_pkg::OUT_BITS - 1)) - M_BITS'(1);
      if (neg_ff) begin
         clamped  = (m > pos_max + M_BITS'(1)) ? pos_max + M_BITS'(1) : m;
         value_in = udisk_pkg::OUT_BITS'(M_BITS'(0) - clamped);
      end else begin
         clamped  = (m > pos_max) ? pos_max : m;
         value_in = udisk_pkg::OUT_BITS'(clamped);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> rtl/uniform_disk_sample_core.sv
// uniform_disk_sample_core: top level, uniform pair to a point on the unit disk.
// Uses udisk_pkg, udisk_sqrt, udisk_sine and udisk_scale.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+------------------------------
//   request  | start, busy, req_data       | taken when start && !busy
//   response | rsp_valid, rsp_data         | one-cycle strobe, no back-off
//
// One item enters per cycle; each result passes through the seven-term sine
// series at two stages per term, plus radian conversion, squaring, final
// product and the two scaling stages. The root runs in parallel over 15
// stages. busy stays low: the pipeline never stalls. Reset clears the valid
// line only; data stages carry no reset.
module uniform_disk_sample_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  udisk_pkg::udisk_req_type  req_data,
   output logic                      rsp_valid,
   output udisk_pkg::udisk_rsp_type  rsp_data
);

   localparam int R_DELAY = udisk_pkg::SINE_LAT - udisk_pkg::SQRT_STAGES;

   logic [udisk_pkg::CORE_LAT-1:0]     valid_ff;
   logic [udisk_pkg::CORE_LAT-1:0]     valid_in;
   udisk_pkg::udisk_quad_type          quad_ff [udisk_pkg::SINE_LAT];
   logic [udisk_pkg::R_BITS-1:0]       r_ff    [R_DELAY];

   logic                               accept;
   logic [udisk_pkg::PHASE_BITS:0]     phase_s;
   logic [udisk_pkg::PHASE_BITS:0]     phase_c;
   logic [udisk_pkg::R_BITS-1:0]       root;
   logic [udisk_pkg::X_BITS-1:0]       sp;
   logic [udisk_pkg::X_BITS-1:0]       cp;
   logic [udisk_pkg::X_BITS-1:0]       smag;
   logic [udisk_pkg::X_BITS-1:0]       cmag;
   logic                               sneg;
   logic                               cneg;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Split the angle into quadrant and phase; the cosine side takes the mirror
   assign phase_s = {1'b0, req_data.angle_fraction[udisk_pkg::PHASE_BITS-1:0]};
   assign phase_c = ((udisk_pkg::PHASE_BITS+1)'(1) << udisk_pkg::PHASE_BITS) - phase_s;

   // Advance the valid line
   assign valid_in = {valid_ff[udisk_pkg::CORE_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Carry quadrant and radius alongside the sine lanes
   always_ff @(posedge clock) begin
      quad_ff[0] <= udisk_pkg::udisk_quad_type'(
                       req_data.angle_fraction[udisk_pkg::IN_BITS-1 -: 2]);
      for (int i = 1; i < udisk_pkg::SINE_LAT; i++) begin
         quad_ff[i] <= quad_ff[i-1];
      end
      r_ff[0] <= root;
      for (int i = 1; i < R_DELAY; i++) begin
         r_ff[i] <= r_ff[i-1];
      end
   end

   udisk_sqrt u_sqrt (
      .clock          (clock),
      .radius_uniform (req_data.radius_uniform),
      .root           (root)
   );

   udisk_sine u_sine_s (
      .clock (clock),
      .phase (phase_s),
      .sine  (sp)
   );

   udisk_sine u_sine_c (
      .clock (clock),
      .phase (phase_c),
      .sine  (cp)
   );

   // Fold the quadrant into magnitudes and signs
   always_comb begin
      case (quad_ff[udisk_pkg::SINE_LAT-1])
         udisk_pkg::QUAD_FIRST: begin
            smag = sp; sneg = 1'b0; cmag = cp; cneg = 1'b0;
         end
         udisk_pkg::QUAD_SECOND: begin
            smag = cp; sneg = 1'b0; cmag = sp; cneg = 1'b1;
         end
         udisk_pkg::QUAD_THIRD: begin
            smag = sp; sneg = 1'b1; cmag = cp; cneg = 1'b1;
         end
         default: begin
            smag = cp; sneg = 1'b1; cmag = sp; cneg = 1'b0;
         end
      endcase
   end

   udisk_scale u_scale_x (
      .clock     (clock),
      .radius    (r_ff[R_DELAY-1]),
      .magnitude (smag),
      .negative  (sneg),
      .value     (rsp_data.point_x)
   );

   udisk_scale u_scale_y (
      .clock     (clock),
      .radius    (r_ff[R_DELAY-1]),
      .magnitude (cmag),
      .negative  (cneg),
      .value     (rsp_data.point_y)
   );

   assign rsp_valid = valid_ff[udisk_pkg::CORE_LAT-1];

   // A result only follows an item taken the pipeline depth earlier
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, udisk_pkg::CORE_LAT))
      else $error("result without a matching item");

   // Zero radius gives the origin
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.radius_uniform == '0, udisk_pkg::CORE_LAT))
      |-> (rsp_data.point_x == '0 && rsp_data.point_y == '0))
      else $error("zero radius did not give the origin");

   // Zero angle puts the point on the y axis, non-negative side
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.angle_fraction == '0, udisk_pkg::CORE_LAT))
      |-> (rsp_data.point_x == '0 && !rsp_data.point_y[udisk_pkg::OUT_BITS-1]))
      else $error("zero angle left the positive y axis");

endmodule
